>>> sv/legendre_poly_eval_unit_macros.svh
// assertion macros for the legendre polynomial evaluator checker
// expects clk and rst_n in scope where a macro is used
`ifndef LEGENDRE_POLY_EVAL_UNIT_MACROS_SVH
`define LEGENDRE_POLY_EVAL_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define LEGP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define LEGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/legp_pkg.sv
// shared types, constants and the step micro-program of the legendre evaluator
// no dependencies
package legp_pkg;

    // fixed field widths
    localparam int DATA_W  = 48;
    localparam int POINT_W = 32;
    localparam int ORDER_W = 5;

    // parameter defaults
    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 30;

    // operand source codes
    localparam int SRC_W = 4;
    localparam logic [SRC_W-1:0] SRC_X      = 4'd0;
    localparam logic [SRC_W-1:0] SRC_COEF_A = 4'd1;
    localparam logic [SRC_W-1:0] SRC_COEF_B = 4'd2;
    localparam logic [SRC_W-1:0] SRC_T      = 4'd3;
    localparam logic [SRC_W-1:0] SRC_U      = 4'd4;
    localparam logic [SRC_W-1:0] SRC_CUR0   = 4'd5;
    localparam logic [SRC_W-1:0] SRC_CUR1   = 4'd6;
    localparam logic [SRC_W-1:0] SRC_CUR2   = 4'd7;
    localparam logic [SRC_W-1:0] SRC_PREV0  = 4'd8;
    localparam logic [SRC_W-1:0] SRC_PREV1  = 4'd9;
    localparam logic [SRC_W-1:0] SRC_PREV2  = 4'd10;

    // write-back destination codes
    localparam int DST_W = 3;
    localparam logic [DST_W-1:0] DST_T    = 3'd0;
    localparam logic [DST_W-1:0] DST_U    = 3'd1;
    localparam logic [DST_W-1:0] DST_NXT0 = 3'd2;
    localparam logic [DST_W-1:0] DST_NXT1 = 3'd3;
    localparam logic [DST_W-1:0] DST_NXT2 = 3'd4;

    // micro-op kinds
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_MUL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUB = 2'd2;

    // micro-program of one recurrence step
    localparam int UOP_W = 4;
    localparam logic [UOP_W-1:0] UP_AX   = 4'd0;   // t = a*x
    localparam logic [UOP_W-1:0] UP_AXP  = 4'd1;   // t = t*p
    localparam logic [UOP_W-1:0] UP_BP0  = 4'd2;   // u = b*pm
    localparam logic [UOP_W-1:0] UP_V    = 4'd3;   // nxt0 = t - u
    localparam logic [UOP_W-1:0] UP_XD1  = 4'd4;   // t = x*p'
    localparam logic [UOP_W-1:0] UP_SD1  = 4'd5;   // t = p + t
    localparam logic [UOP_W-1:0] UP_AD1  = 4'd6;   // t = a*t
    localparam logic [UOP_W-1:0] UP_BP1  = 4'd7;   // u = b*pm'
    localparam logic [UOP_W-1:0] UP_D1   = 4'd8;   // nxt1 = t - u
    localparam logic [UOP_W-1:0] UP_DD   = 4'd9;   // t = p' + p'
    localparam logic [UOP_W-1:0] UP_XD2  = 4'd10;  // u = x*p''
    localparam logic [UOP_W-1:0] UP_SD2  = 4'd11;  // t = t + u
    localparam logic [UOP_W-1:0] UP_AD2  = 4'd12;  // t = a*t
    localparam logic [UOP_W-1:0] UP_BP2  = 4'd13;  // u = b*pm''
    localparam logic [UOP_W-1:0] UP_D2   = 4'd14;  // nxt2 = t - u
    localparam logic [UOP_W-1:0] UP_LAST = UP_D2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SRC_W-1:0]  src_a;
        logic [SRC_W-1:0]  src_b;
        logic [DST_W-1:0]  dst;
    } legp_uop_t;

    // controller to datapath commands
    typedef struct packed {
        logic             init;
        logic             shift;
        logic             load_out;
        logic             mul_start;
        logic             wr_en;
        logic             use_mul;
        logic             sub;
        logic [SRC_W-1:0] src_a;
        logic [SRC_W-1:0] src_b;
        logic [DST_W-1:0] dst;
    } legp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic mul_busy;
        logic mul_done;
    } legp_stat_t;

    function automatic legp_uop_t legp_uop_decode(input logic [UOP_W-1:0] idx);
        legp_uop_t u;
        case (idx)
            UP_AX:   u = '{KIND_MUL, SRC_COEF_A, SRC_X,      DST_T};
            UP_AXP:  u = '{KIND_MUL, SRC_T,      SRC_CUR0,   DST_T};
            UP_BP0:  u = '{KIND_MUL, SRC_COEF_B, SRC_PREV0,  DST_U};
            UP_V:    u = '{KIND_SUB, SRC_T,      SRC_U,      DST_NXT0};
            UP_XD1:  u = '{KIND_MUL, SRC_X,      SRC_CUR1,   DST_T};
            UP_SD1:  u = '{KIND_ADD, SRC_CUR0,   SRC_T,      DST_T};
            UP_AD1:  u = '{KIND_MUL, SRC_COEF_A, SRC_T,      DST_T};
            UP_BP1:  u = '{KIND_MUL, SRC_COEF_B, SRC_PREV1,  DST_U};
            UP_D1:   u = '{KIND_SUB, SRC_T,      SRC_U,      DST_NXT1};
            UP_DD:   u = '{KIND_ADD, SRC_CUR1,   SRC_CUR1,   DST_T};
            UP_XD2:  u = '{KIND_MUL, SRC_X,      SRC_CUR2,   DST_U};
            UP_SD2:  u = '{KIND_ADD, SRC_T,      SRC_U,      DST_T};
            UP_AD2:  u = '{KIND_MUL, SRC_COEF_A, SRC_T,      DST_T};
            UP_BP2:  u = '{KIND_MUL, SRC_COEF_B, SRC_PREV2,  DST_U};
            UP_D2:   u = '{KIND_SUB, SRC_T,      SRC_U,      DST_NXT2};
            default: u = '{KIND_ADD, SRC_T,      SRC_U,      DST_T};
        endcase
        return u;
    endfunction

endpackage

>>> sv/legp_mul.sv
// iterative signed fixed-point multiplier: four half-width partial products,
// round half away from zero, clip to the data range; uses legp_pkg
module legp_mul
    import legp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     busy,
    output logic                     done,
    output logic signed [DATA_W-1:0] res,
    output logic                     ovf
);

    localparam int HALF_W = DATA_W / 2;
    localparam int PROD_W = 2 * DATA_W;
    localparam int CNT_W  = 3;
    localparam logic [CNT_W-1:0] CNT_FIRST_ACC = 3'd1;
    localparam logic [CNT_W-1:0] CNT_LAST_PP   = 3'd3;
    localparam logic [CNT_W-1:0] CNT_LAST_ACC  = 3'd4;
    localparam logic [CNT_W-1:0] CNT_ROUND     = 3'd5;
    localparam logic [CNT_W-1:0] CNT_SIGN      = 3'd6;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] ma_reg;
    logic [DATA_W-1:0] mb_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] pp_reg;
    logic [1:0]        pp_sel_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [DATA_W-1:0] qmag_reg;
    logic              ovf_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [DATA_W-1:0] product;
    logic [PROD_W-1:0] pp_shifted;
    logic [PROD_W-1:0] round_sum;
    logic [PROD_W-1:0] q_full;
    logic [PROD_W-1:0] lim;
    logic              clip;

    // operand magnitudes
    assign a_mag = a[DATA_W-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag = b[DATA_W-1] ? $unsigned(-b) : $unsigned(b);

    // one half-width partial product per cycle
    assign op_x    = cnt_reg[1] ? ma_reg[DATA_W-1:HALF_W] : ma_reg[HALF_W-1:0];
    assign op_y    = cnt_reg[0] ? mb_reg[DATA_W-1:HALF_W] : mb_reg[HALF_W-1:0];
    assign product = op_x * op_y;

    // align the registered partial product
    always_comb
    begin
        case (pp_sel_reg)
            2'b00:   pp_shifted = PROD_W'(pp_reg);
            2'b01:   pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'b10:   pp_shifted = PROD_W'(pp_reg) << HALF_W;
            2'b11:   pp_shifted = PROD_W'(pp_reg) << DATA_W;
            default: pp_shifted = PROD_W'(pp_reg);
        endcase
    end

    // round to nearest and clip the magnitude
    assign round_sum = acc_reg + (PROD_W'(1) << (FRAC_BITS - 1));
    assign q_full    = round_sum >> FRAC_BITS;
    assign lim       = neg_reg ? (PROD_W'(1) << (DATA_W - 1))
                               : ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
    assign clip      = q_full > lim;

    // sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_SIGN);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNT_SIGN)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a_mag;
            mb_reg  <= b_mag;
            neg_reg <= a[DATA_W-1] ^ b[DATA_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg <= CNT_LAST_PP)
            begin
                pp_reg     <= product;
                pp_sel_reg <= cnt_reg[1:0];
            end
            if ((cnt_reg >= CNT_FIRST_ACC) && (cnt_reg <= CNT_LAST_ACC))
                acc_reg <= acc_reg + pp_shifted;
            if (cnt_reg == CNT_ROUND)
            begin
                qmag_reg <= clip ? lim[DATA_W-1:0] : q_full[DATA_W-1:0];
                ovf_reg  <= clip;
            end
            if (cnt_reg == CNT_SIGN)
                res_reg <= neg_reg ? $signed(DATA_W'(0) - qmag_reg) : $signed(qmag_reg);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;
    assign ovf  = ovf_reg;

endmodule

>>> sv/legp_ctrl.sv
// controller of the legendre evaluator: handshakes, order register, step and
// micro-op sequencing; uses legp_pkg
module legp_ctrl
    import legp_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    localparam int JW       = $clog2(MAX_ORDER + 2)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  logic               cfg_we,
    input  logic [ORDER_W-1:0] cfg_wdata,
    input  legp_stat_t         stat,
    output legp_cmd_t          cmd,
    output logic [JW-1:0]      step_idx
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_ISSUE  = 3'd1;
    localparam logic [ST_W-1:0] ST_WAIT   = 3'd2;
    localparam logic [ST_W-1:0] ST_ADV    = 3'd3;
    localparam logic [ST_W-1:0] ST_FINISH = 3'd4;

    logic [ST_W-1:0]    state_reg, state_next;
    logic [UOP_W-1:0]   uop_reg, uop_next;
    logic [JW-1:0]      j_reg, j_next;
    logic [ORDER_W-1:0] order_reg;
    logic               out_valid_reg, out_valid_next;

    logic [JW-1:0]      n_eff;
    legp_uop_t          uop;

    // order clamps to the largest supported one
    always_comb
    begin
        if (32'(order_reg) > MAX_ORDER)
            n_eff = JW'(MAX_ORDER);
        else
            n_eff = JW'(order_reg);
    end

    assign uop = legp_uop_decode(uop_reg);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        uop_next       = uop_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.src_a      = uop.src_a;
        cmd.src_b      = uop.src_b;
        cmd.dst        = uop.dst;
        cmd.sub        = (uop.kind == KIND_SUB);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.init   = 1'b1;
                    j_next     = JW'(1);
                    uop_next   = UP_AX;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (uop.kind == KIND_MUL)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_WAIT;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (uop_reg == UP_LAST)
                        state_next = ST_ADV;
                    else
                        uop_next = uop_reg + UOP_W'(1);
                end
            end
            ST_WAIT:
            begin
                cmd.use_mul = 1'b1;
                if (stat.mul_done && !stat.mul_busy)
                begin
                    cmd.wr_en = 1'b1;
                    if (uop_reg == UP_LAST)
                        state_next = ST_ADV;
                    else
                    begin
                        uop_next   = uop_reg + UOP_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ADV:
            begin
                // the extra step for order n+1 ends the item
                if (j_reg == (n_eff + JW'(1)))
                    state_next = ST_FINISH;
                else
                begin
                    cmd.shift  = 1'b1;
                    j_next     = j_reg + JW'(1);
                    uop_next   = UP_AX;
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            uop_reg       <= UP_AX;
            j_reg         <= JW'(1);
            order_reg     <= ORDER_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            uop_reg       <= uop_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                order_reg <= cfg_wdata;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign step_idx  = j_reg;

endmodule

>>> sv/legp_dpath.sv
// datapath of the legendre evaluator: coefficient table, value registers,
// saturating adder, shared multiplier and result registers; uses legp_pkg, legp_mul
module legp_dpath
    import legp_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int JW       = $clog2(MAX_ORDER + 2)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  legp_cmd_t                 cmd,
    input  logic [JW-1:0]             step_idx,
    input  logic signed [POINT_W-1:0] point,
    output legp_stat_t                stat,
    output logic signed [DATA_W-1:0]  p_n,
    output logic signed [DATA_W-1:0]  dp_n,
    output logic signed [DATA_W-1:0]  d2p_n,
    output logic signed [DATA_W-1:0]  p_next,
    output logic signed [DATA_W-1:0]  dp_next,
    output logic signed [DATA_W-1:0]  d2p_next,
    output logic                      overflow
);

    localparam int TAB_D = MAX_ORDER + 2;
    localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic [DATA_W-1:0] coef_a_tab [TAB_D];
    logic [DATA_W-1:0] coef_b_tab [TAB_D];

    logic signed [DATA_W-1:0] x_reg, t_reg, u_reg;
    logic signed [DATA_W-1:0] cur0_reg, cur1_reg, cur2_reg;
    logic signed [DATA_W-1:0] prev0_reg, prev1_reg, prev2_reg;
    logic signed [DATA_W-1:0] nxt0_reg, nxt1_reg, nxt2_reg;
    logic                     ovf_reg;
    logic signed [DATA_W-1:0] p_n_reg, dp_n_reg, d2p_n_reg;
    logic signed [DATA_W-1:0] p_next_reg, dp_next_reg, d2p_next_reg;
    logic                     overflow_reg;

    logic signed [DATA_W-1:0] opa, opb;
    logic signed [DATA_W:0]   alu_sum;
    logic signed [DATA_W-1:0] alu_res;
    logic                     alu_ovf;
    logic signed [DATA_W-1:0] mul_res;
    logic                     mul_ovf;
    logic signed [DATA_W-1:0] wb_val;
    logic                     wb_ovf;

    // recurrence coefficients (2j-1)/j and (j-1)/j, rounded to nearest
    for (genvar gj = 0; gj < TAB_D; gj++)
    begin : g_coef
        if (gj == 0)
        begin : g_unused
            assign coef_a_tab[gj] = '0;
            assign coef_b_tab[gj] = '0;
        end
        else
        begin : g_entry
            localparam logic [63:0] NUM_A  = 64'(2 * gj - 1) << FRAC_BITS;
            localparam logic [63:0] NUM_B  = 64'(gj - 1) << FRAC_BITS;
            localparam logic [63:0] COEF_A = (NUM_A + 64'(gj / 2)) / 64'(gj);
            localparam logic [63:0] COEF_B = (NUM_B + 64'(gj / 2)) / 64'(gj);
            assign coef_a_tab[gj] = COEF_A[DATA_W-1:0];
            assign coef_b_tab[gj] = COEF_B[DATA_W-1:0];
        end
    end

    function automatic logic signed [DATA_W-1:0] pick(
        input logic [SRC_W-1:0]       src,
        input logic signed [DATA_W-1:0] x_v, t_v, u_v, ca, cb,
        input logic signed [DATA_W-1:0] c0, c1, c2, p0, p1, p2
    );
        logic signed [DATA_W-1:0] v;
        case (src)
            SRC_X:      v = x_v;
            SRC_COEF_A: v = ca;
            SRC_COEF_B: v = cb;
            SRC_T:      v = t_v;
            SRC_U:      v = u_v;
            SRC_CUR0:   v = c0;
            SRC_CUR1:   v = c1;
            SRC_CUR2:   v = c2;
            SRC_PREV0:  v = p0;
            SRC_PREV1:  v = p1;
            SRC_PREV2:  v = p2;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // operand selection
    assign opa = pick(cmd.src_a, x_reg, t_reg, u_reg,
                      $signed(coef_a_tab[step_idx]), $signed(coef_b_tab[step_idx]),
                      cur0_reg, cur1_reg, cur2_reg, prev0_reg, prev1_reg, prev2_reg);
    assign opb = pick(cmd.src_b, x_reg, t_reg, u_reg,
                      $signed(coef_a_tab[step_idx]), $signed(coef_b_tab[step_idx]),
                      cur0_reg, cur1_reg, cur2_reg, prev0_reg, prev1_reg, prev2_reg);

    // saturating add and subtract
    always_comb
    begin
        if (cmd.sub)
            alu_sum = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
        else
            alu_sum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
        alu_ovf = alu_sum[DATA_W] != alu_sum[DATA_W-1];
        if (alu_ovf)
            alu_res = alu_sum[DATA_W] ? VAL_MIN : VAL_MAX;
        else
            alu_res = alu_sum[DATA_W-1:0];
    end

    // shared multiplier
    legp_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (opa),
        .b     (opb),
        .busy  (stat.mul_busy),
        .done  (stat.mul_done),
        .res   (mul_res),
        .ovf   (mul_ovf)
    );

    assign wb_val = cmd.use_mul ? mul_res : alu_res;
    assign wb_ovf = cmd.use_mul ? mul_ovf : alu_ovf;

    // value registers and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            x_reg     <= {{(DATA_W-POINT_W){point[POINT_W-1]}}, point};
            cur0_reg  <= ONE;
            cur1_reg  <= '0;
            cur2_reg  <= '0;
            prev0_reg <= '0;
            prev1_reg <= '0;
            prev2_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        if (cmd.wr_en)
        begin
            ovf_reg <= ovf_reg | wb_ovf;
            case (cmd.dst)
                DST_T:    t_reg    <= wb_val;
                DST_U:    u_reg    <= wb_val;
                DST_NXT0: nxt0_reg <= wb_val;
                DST_NXT1: nxt1_reg <= wb_val;
                DST_NXT2: nxt2_reg <= wb_val;
                default:  t_reg    <= wb_val;
            endcase
        end
        if (cmd.shift)
        begin
            prev0_reg <= cur0_reg;
            prev1_reg <= cur1_reg;
            prev2_reg <= cur2_reg;
            cur0_reg  <= nxt0_reg;
            cur1_reg  <= nxt1_reg;
            cur2_reg  <= nxt2_reg;
        end
        if (cmd.load_out)
        begin
            p_n_reg      <= cur0_reg;
            dp_n_reg     <= cur1_reg;
            d2p_n_reg    <= cur2_reg;
            p_next_reg   <= nxt0_reg;
            dp_next_reg  <= nxt1_reg;
            d2p_next_reg <= nxt2_reg;
            overflow_reg <= ovf_reg;
        end
    end

    assign p_n      = p_n_reg;
    assign dp_n     = dp_n_reg;
    assign d2p_n    = d2p_n_reg;
    assign p_next   = p_next_reg;
    assign dp_next  = dp_next_reg;
    assign d2p_next = d2p_next_reg;
    assign overflow = overflow_reg;

endmodule

>>> sv/legendre_poly_eval_unit.sv
// Legendre polynomial evaluator. For each point x (signed, FRAC_BITS fraction
// bits) it returns P_n, P_n', P_n'' and P_{n+1}, P_{n+1}', P_{n+1}'' in signed
// 48-bit fixed point with the same fraction, saturated, plus a flag set when
// any intermediate value saturated. n is the order register (reset 1),
// clamped to MAX_ORDER; write it only while no point is in flight. One point
// is worked at a time: each recurrence step runs fifteen micro-ops, nine of
// them products on one shared multiplier that builds each 48x48 product from
// four 24x24 partial products. A finished result sits in the output register
// while the next point is accepted.
// uses legp_pkg, legp_ctrl, legp_dpath
module legendre_poly_eval_unit
    import legp_pkg::*;
#(
    parameter int MAX_ORDER = MAX_ORDER_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ORDER_W-1:0]        cfg_wdata,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [POINT_W-1:0] point,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  p_n,
    output logic signed [DATA_W-1:0]  dp_n,
    output logic signed [DATA_W-1:0]  d2p_n,
    output logic signed [DATA_W-1:0]  p_next,
    output logic signed [DATA_W-1:0]  dp_next,
    output logic signed [DATA_W-1:0]  d2p_next,
    output logic                      overflow
);

    localparam int JW = $clog2(MAX_ORDER + 2);

    legp_cmd_t     cmd;
    legp_stat_t    stat;
    logic [JW-1:0] step_idx;

    // sequencing
    legp_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .cmd       (cmd),
        .step_idx  (step_idx)
    );

    // arithmetic
    legp_dpath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .step_idx (step_idx),
        .point    (point),
        .stat     (stat),
        .p_n      (p_n),
        .dp_n     (dp_n),
        .d2p_n    (d2p_n),
        .p_next   (p_next),
        .dp_next  (dp_next),
        .d2p_next (d2p_next),
        .overflow (overflow)
    );

endmodule

>>> sv/legp_checker.sv
// port-level assertions for the legendre evaluator, bound to the top level
// uses legp_pkg and legendre_poly_eval_unit_macros.svh
`include "legendre_poly_eval_unit_macros.svh"

module legp_checker
    import legp_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic signed [DATA_W-1:0]  p_n,
    input logic signed [DATA_W-1:0]  dp_n,
    input logic signed [DATA_W-1:0]  d2p_n,
    input logic signed [DATA_W-1:0]  p_next,
    input logic signed [DATA_W-1:0]  dp_next,
    input logic signed [DATA_W-1:0]  d2p_next,
    input logic                      overflow
);

    logic [6*DATA_W:0] out_beat;

    // result payload as one vector
    assign out_beat = {p_n, dp_n, d2p_n, p_next, dp_next, d2p_next, overflow};

    // an accepted point keeps the input side closed while it is worked
    `LEGP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

    // a result beat only appears at the end of a busy stretch
    `LEGP_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result without work")

    // a stalled result beat stays offered
    `LEGP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")

    // a stalled result beat keeps its payload
    `LEGP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_beat), "beat changed")

endmodule

bind legendre_poly_eval_unit legp_checker u_legp_checker (.*);
